/* sv/ccm_pkg.sv */
// Shared types and constants for the circle and cone mask shader.
// Used by every module of the shader; depends on nothing else.
package ccm_pkg;

  localparam int FRAC_BITS = 8;
  localparam int MAX_DIM = 16384;
  localparam int RAD_BITS = 15 + FRAC_BITS;
  localparam int POS_BITS = 16 + FRAC_BITS;
  localparam int UNIT_BITS = 14;
  localparam int COV_BITS = 16;

  localparam int SQRT_STEPS = 31;
  localparam int SQRT_RAD_W = 2 * SQRT_STEPS;
  localparam int DIV_STEPS = 17;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 31;
  localparam int VEC_W = 26;
  localparam int UNIT_W = 16;
  localparam int NORM_W = 30;

  localparam logic [16:0] COV_ONE = 17'h10000;
  localparam logic [16:0] LIMIT_MIN_COV = 17'd7;
  localparam logic [14:0] DIM_MAX = 15'(MAX_DIM);
  localparam logic signed [21:0] SIDE_LIMIT = -22'sd49152;
  localparam logic signed [32:0] TRUNC_BIAS = 33'sd16383;

  typedef enum logic [2:0] {
    REG_IMAGE_SIZE     = 3'd0,
    REG_INNER_RGBA     = 3'd1,
    REG_OUTER_RGBA     = 3'd2,
    REG_CIRCLE_INNER   = 3'd3,
    REG_CIRCLE_OUTER   = 3'd4,
    REG_CONE_COSINES   = 3'd5,
    REG_CONE_ORIGIN    = 3'd6,
    REG_CONE_DIRECTION = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_word_t;

  typedef struct packed {
    logic disc_in;
    logic disc_full;
    logic cone_hit;
    logic cone_full;
    logic limit_out;
    logic limit_ramp;
  } cov_flags_t;

endpackage

/* sv/ccm_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on ccm_pkg for its widths.
module ccm_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ccm_pkg::SQRT_RAD_W-1:0]   rad,
  output logic [ccm_pkg::SQRT_STEPS-1:0]   root
);

  localparam int RW = ccm_pkg::SQRT_RAD_W;
  localparam int N = ccm_pkg::SQRT_STEPS;

  logic [RW-1:0] rem_q [0:N-1];
  logic [N-1:0]  root_q [0:N-1];
  logic [RW-1:0] rem_i [0:N-1];
  logic [N-1:0]  root_i [0:N-1];
  logic [RW-1:0] rem_n [0:N-1];
  logic [N-1:0]  root_n [0:N-1];
  logic [RW:0]   trial [0:N-1];

  always_comb begin
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        rem_i[j] = rad;
        root_i[j] = '0;
      end else begin
        rem_i[j] = rem_q[j-1];
        root_i[j] = root_q[j-1];
      end
      trial[j] = ((RW+1)'(root_i[j]) << (N - j)) + ((RW+1)'(1) << (2 * (N - 1 - j)));
      if ({1'b0, rem_i[j]} >= trial[j]) begin
        rem_n[j] = rem_i[j] - trial[j][RW-1:0];
        root_n[j] = root_i[j] | (N'(1) << (N - 1 - j));
      end else begin
        rem_n[j] = rem_i[j];
        root_n[j] = root_i[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        rem_q[j] <= rem_n[j];
        root_q[j] <= root_n[j];
      end
    end
  end

  assign root = root_q[N-1];

endmodule

/* sv/ccm_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit its width. Depends on ccm_pkg for its widths.
module ccm_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ccm_pkg::DIV_NUM_W-1:0]  num,
  input  logic [ccm_pkg::DIV_DEN_W-1:0]  den,
  output logic [ccm_pkg::DIV_STEPS-1:0]  quo
);

  localparam int NW = ccm_pkg::DIV_NUM_W;
  localparam int DW = ccm_pkg::DIV_DEN_W;
  localparam int N = ccm_pkg::DIV_STEPS;

  logic [NW-1:0] rem_q [0:N-1];
  logic [DW-1:0] den_q [0:N-1];
  logic [N-1:0]  quo_q [0:N-1];
  logic [NW-1:0] rem_i [0:N-1];
  logic [DW-1:0] den_i [0:N-1];
  logic [N-1:0]  quo_i [0:N-1];
  logic [NW-1:0] rem_n [0:N-1];
  logic [N-1:0]  quo_n [0:N-1];
  logic [NW-1:0] sub [0:N-1];

  always_comb begin
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        rem_i[j] = num;
        den_i[j] = den;
        quo_i[j] = '0;
      end else begin
        rem_i[j] = rem_q[j-1];
        den_i[j] = den_q[j-1];
        quo_i[j] = quo_q[j-1];
      end
      sub[j] = NW'(den_i[j]) << (N - 1 - j);
      if (rem_i[j] >= sub[j]) begin
        rem_n[j] = rem_i[j] - sub[j];
        quo_n[j] = quo_i[j] | (N'(1) << (N - 1 - j));
      end else begin
        rem_n[j] = rem_i[j];
        quo_n[j] = quo_i[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        rem_q[j] <= rem_n[j];
        den_q[j] <= den_i[j];
        quo_q[j] <= quo_n[j];
      end
    end
  end

  assign quo = quo_q[N-1];

endmodule

/* sv/ccm_unit.sv */
// Vector normalizer: scales a vector to Q1.14 unit length in 53 stages.
// Depends on ccm_pkg, ccm_isqrt and ccm_div.
module ccm_unit (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ccm_pkg::VEC_W-1:0]    vx,
  input  logic signed [ccm_pkg::VEC_W-1:0]    vy,
  output logic signed [ccm_pkg::UNIT_W-1:0]   ux,
  output logic signed [ccm_pkg::UNIT_W-1:0]   uy
);

  localparam int VW = ccm_pkg::VEC_W;
  localparam int NW = ccm_pkg::NORM_W;
  localparam int DLY_LEN = ccm_pkg::SQRT_STEPS;
  localparam int SGN_LEN = ccm_pkg::SQRT_STEPS + ccm_pkg::DIV_STEPS;

  logic [VW-1:0]     a_ax, a_ay;
  logic [2:0]        a_sgn;
  logic [NW-1:0]     n_ax, n_ay;
  logic [2:0]        n_sgn;
  logic [2*NW-1:0]   q_sx, q_sy;
  logic [NW-1:0]     q_ax, q_ay;
  logic [2:0]        q_sgn;
  logic [2*NW:0]     s_sum;
  logic [NW-1:0]     s_ax, s_ay;
  logic [2:0]        s_sgn;
  logic [NW-1:0]     ax_d [0:DLY_LEN-1];
  logic [NW-1:0]     ay_d [0:DLY_LEN-1];
  logic [2:0]        sgn_d [0:SGN_LEN-1];
  logic [VW:0]       ext_x, ext_y;
  logic [VW-1:0]     mag;
  logic [4:0]        msb;
  logic [4:0]        sh;
  logic [ccm_pkg::SQRT_STEPS-1:0] len;
  logic [ccm_pkg::DIV_STEPS-1:0]  qx, qy;
  logic [ccm_pkg::DIV_NUM_W-1:0]  num_x, num_y;

  always_comb begin
    ext_x = (VW+1)'(vx);
    ext_y = (VW+1)'(vy);
    if (vx < 0) begin
      ext_x = -ext_x;
    end
    if (vy < 0) begin
      ext_y = -ext_y;
    end
  end

  always_comb begin
    mag = (a_ax > a_ay) ? a_ax : a_ay;
    msb = '0;
    for (int b = 0; b < VW; b++) begin
      if (mag[b]) begin
        msb = 5'(b);
      end
    end
    sh = 5'(NW - 1) - msb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax <= ext_x[VW-1:0];
      a_ay <= ext_y[VW-1:0];
      a_sgn <= {vx < 0, vy < 0, (vx == '0) && (vy == '0)};
      n_ax <= NW'(a_ax) << sh;
      n_ay <= NW'(a_ay) << sh;
      n_sgn <= a_sgn;
      q_sx <= n_ax * n_ax;
      q_sy <= n_ay * n_ay;
      q_ax <= n_ax;
      q_ay <= n_ay;
      q_sgn <= n_sgn;
      s_sum <= (2*NW+1)'(q_sx) + (2*NW+1)'(q_sy);
      s_ax <= q_ax;
      s_ay <= q_ay;
      s_sgn <= q_sgn;
      ax_d[0] <= s_ax;
      ay_d[0] <= s_ay;
      for (int k = 1; k < DLY_LEN; k++) begin
        ax_d[k] <= ax_d[k-1];
        ay_d[k] <= ay_d[k-1];
      end
      sgn_d[0] <= s_sgn;
      for (int k = 1; k < SGN_LEN; k++) begin
        sgn_d[k] <= sgn_d[k-1];
      end
    end
  end

  ccm_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  ({1'b0, s_sum}),
    .root (len)
  );

  assign num_x = {4'b0, ax_d[DLY_LEN-1], 14'b0};
  assign num_y = {4'b0, ay_d[DLY_LEN-1], 14'b0};

  ccm_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (num_x),
    .den (len),
    .quo (qx)
  );

  ccm_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (num_y),
    .den (len),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      if (sgn_d[SGN_LEN-1][0]) begin
        ux <= '0;
        uy <= '0;
      end else begin
        ux <= sgn_d[SGN_LEN-1][2] ? -$signed({1'b0, qx[14:0]}) : $signed({1'b0, qx[14:0]});
        uy <= sgn_d[SGN_LEN-1][1] ? -$signed({1'b0, qy[14:0]}) : $signed({1'b0, qy[14:0]});
      end
    end
  end

endmodule

/* sv/circle_cone_mask_shader_core.sv */
// Top level of the circle and cone mask shader: registers, pipeline and blend.
// Depends on ccm_pkg, ccm_isqrt, ccm_div and ccm_unit.
//
//   channel   direction  handshake                  payload
//   pixel     in         pixel_valid, pixel_stall   pixel (ccm_pkg::pixel_word_t)
//   color     out        color_valid, color_stall   color (ccm_pkg::color_word_t)
//   config    in         cfg_we                     cfg_index, cfg_data
//
// One pixel word is accepted every cycle while the output word is not stalled.
// The pipeline depth is set by the vector normalizers: a 31-stage square root followed
// by a 17-stage divider, then the coverage divider and the blend multiplier.
// Reset clears all valid bits and loads the register defaults.
// When the output word is stalled the whole pipeline holds and pixel_stall rises.
module circle_cone_mask_shader_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  ccm_pkg::pixel_word_t  pixel,
  output logic                  color_valid,
  input  logic                  color_stall,
  output ccm_pkg::color_word_t  color,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [47:0]           cfg_data
);

  localparam int LAT = 74;
  localparam int D_DLY = 22;
  localparam int F_DLY = ccm_pkg::DIV_STEPS;

  logic [29:0] image_size;
  logic [31:0] inner_rgba;
  logic [31:0] outer_rgba;
  logic [2*ccm_pkg::RAD_BITS-1:0] circle_inner;
  logic [2*ccm_pkg::RAD_BITS-1:0] circle_outer;
  logic [32:0] cone_cosines;
  logic [2*ccm_pkg::POS_BITS-1:0] cone_origin;
  logic [2*ccm_pkg::POS_BITS-1:0] cone_direction;

  logic [LAT:1] vld;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= {15'd64, 15'd64};
      inner_rgba <= '1;
      outer_rgba <= '0;
      circle_inner <= '0;
      circle_outer <= '0;
      cone_cosines <= '0;
      cone_origin <= '0;
      cone_direction <= '0;
    end else if (cfg_we) begin
      case (ccm_pkg::cfg_reg_t'(cfg_index))
        ccm_pkg::REG_IMAGE_SIZE:     image_size <= cfg_data[29:0];
        ccm_pkg::REG_INNER_RGBA:     inner_rgba <= cfg_data[31:0];
        ccm_pkg::REG_OUTER_RGBA:     outer_rgba <= cfg_data[31:0];
        ccm_pkg::REG_CIRCLE_INNER:   circle_inner <= cfg_data[2*ccm_pkg::RAD_BITS-1:0];
        ccm_pkg::REG_CIRCLE_OUTER:   circle_outer <= cfg_data[2*ccm_pkg::RAD_BITS-1:0];
        ccm_pkg::REG_CONE_COSINES:   cone_cosines <= cfg_data[32:0];
        ccm_pkg::REG_CONE_ORIGIN:    cone_origin <= cfg_data;
        ccm_pkg::REG_CONE_DIRECTION: cone_direction <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !(vld[LAT] && color_stall);
  assign pixel_stall = !en;
  assign color_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], pixel_valid};
    end
  end

  // Stage 1: pixel offsets and the three cone vectors.
  logic [14:0] w_raw, h_raw, w_cl, h_cl;
  logic [13:0] px, py;
  logic signed [23:0] ox, oy, tx, ty;
  logic signed [14:0] dx1, dy1;
  logic signed [ccm_pkg::VEC_W-1:0] vx1, vy1, nx1, ny1;

  always_comb begin
    w_raw = image_size[29:15];
    h_raw = image_size[14:0];
    w_cl = (w_raw == '0) ? 15'd1 : (w_raw > ccm_pkg::DIM_MAX) ? ccm_pkg::DIM_MAX : w_raw;
    h_cl = (h_raw == '0) ? 15'd1 : (h_raw > ccm_pkg::DIM_MAX) ? ccm_pkg::DIM_MAX : h_raw;
    px = (w_cl > 15'd1) ? pixel.pixel_x : '0;
    py = (h_cl > 15'd1) ? pixel.pixel_y : '0;
    ox = cone_origin[47:24];
    oy = cone_origin[23:0];
    tx = cone_direction[47:24];
    ty = cone_direction[23:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= $signed({1'b0, px}) - $signed({1'b0, w_cl[14:1]});
      dy1 <= $signed({1'b0, py}) - $signed({1'b0, h_cl[14:1]});
      vx1 <= $signed({4'b0, px, 8'b0}) - ccm_pkg::VEC_W'(ox);
      vy1 <= $signed({4'b0, py, 8'b0}) - ccm_pkg::VEC_W'(oy);
      nx1 <= -ccm_pkg::VEC_W'(tx);
      ny1 <= -ccm_pkg::VEC_W'(ty);
    end
  end

  // Distance to the center: square, then root of the Q.16 scaled square.
  logic signed [30:0] dsq_full;
  logic [29:0] dsq2;
  logic [ccm_pkg::SQRT_STEPS-1:0] d_root;
  logic [22:0] d_dly [0:D_DLY-1];

  assign dsq_full = 31'(dx1 * dx1) + 31'(dy1 * dy1);

  always_ff @(posedge clk) begin
    if (en) begin
      dsq2 <= dsq_full[29:0];
      d_dly[0] <= d_root[22:0];
      for (int k = 1; k < D_DLY; k++) begin
        d_dly[k] <= d_dly[k-1];
      end
    end
  end

  ccm_isqrt u_dist (
    .clk  (clk),
    .en   (en),
    .rad  ({16'b0, dsq2, 16'b0}),
    .root (d_root)
  );

  logic signed [ccm_pkg::UNIT_W-1:0] ax, ay, bx, by, cx, cy;

  ccm_unit u_axis (
    .clk (clk), .en (en), .vx (nx1), .vy (ny1), .ux (ax), .uy (ay)
  );

  ccm_unit u_view (
    .clk (clk), .en (en), .vx (vx1), .vy (vy1), .ux (bx), .uy (by)
  );

  ccm_unit u_side (
    .clk (clk), .en (en),
    .vx  (ccm_pkg::VEC_W'(dx1)), .vy (ccm_pkg::VEC_W'(dy1)),
    .ux  (cx), .uy (cy)
  );

  // Dot products, truncated toward zero.
  logic signed [32:0] kdot, sdot, kadj, sadj;
  logic signed [16:0] kd, sd;

  always_comb begin
    kdot = 33'(bx * ax) + 33'(by * ay);
    sdot = 33'(bx * cx) + 33'(by * cy);
    kadj = (kdot < 0) ? kdot + ccm_pkg::TRUNC_BIAS : kdot;
    sadj = (sdot < 0) ? sdot + ccm_pkg::TRUNC_BIAS : sdot;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd <= kadj[30:14];
      sd <= sadj[30:14];
    end
  end

  // Ramp numerators, divisors and the decision flags.
  logic [22:0] d55, r_in, e_in, r_lim, s_lim;
  logic [23:0] re_sum, rs_sum, re_diff, rs_diff;
  logic signed [15:0] cos_c, cos_cs;
  logic signed [17:0] kmc, cmc;
  logic signed [21:0] sd10;
  ccm_pkg::cov_flags_t fl_n;
  ccm_pkg::cov_flags_t fl_d [0:F_DLY-1];
  logic [ccm_pkg::DIV_STEPS-1:0] qd, ql, qc;

  always_comb begin
    d55 = d_dly[D_DLY-1];
    r_in = circle_inner[45:23];
    e_in = circle_inner[22:0];
    r_lim = circle_outer[45:23];
    s_lim = circle_outer[22:0];
    re_sum = {1'b0, r_in} + {1'b0, e_in};
    rs_sum = {1'b0, r_lim} + {1'b0, s_lim};
    re_diff = re_sum - {1'b0, d55};
    rs_diff = rs_sum - {1'b0, d55};
    cos_c = cone_cosines[31:16];
    cos_cs = cone_cosines[15:0];
    kmc = 18'(kd) - 18'(cos_cs);
    cmc = 18'(cos_c) - 18'(cos_cs);
    sd10 = 22'(sd) * 22'sd10;
    fl_n.disc_in = {1'b0, d55} <= re_sum;
    fl_n.disc_full = d55 <= r_in;
    fl_n.cone_hit = cone_cosines[32] && (kd > 17'(cos_cs)) && (sd10 > ccm_pkg::SIDE_LIMIT);
    fl_n.cone_full = kd > 17'(cos_c);
    fl_n.limit_out = d55 > r_lim;
    fl_n.limit_ramp = {1'b0, d55} < rs_sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_d[0] <= fl_n;
      for (int k = 1; k < F_DLY; k++) begin
        fl_d[k] <= fl_d[k-1];
      end
    end
  end

  ccm_div u_disc_div (
    .clk (clk), .en (en),
    .num ({8'b0, re_diff, 16'b0}), .den ({8'b0, e_in}), .quo (qd)
  );

  ccm_div u_limit_div (
    .clk (clk), .en (en),
    .num ({8'b0, rs_diff, 16'b0}), .den ({8'b0, s_lim}), .quo (ql)
  );

  ccm_div u_cone_div (
    .clk (clk), .en (en),
    .num ({15'b0, kmc[16:0], 16'b0}), .den ({14'b0, cmc[16:0]}), .quo (qc)
  );

  // Coverage: larger of disc and cone, then capped by the outer limit.
  ccm_pkg::cov_flags_t fl72;
  logic [16:0] cov_a, cov_t, cov_n, cov;

  always_comb begin
    fl72 = fl_d[F_DLY-1];
    cov_a = fl72.disc_in ? (fl72.disc_full ? ccm_pkg::COV_ONE : qd) : '0;
    cov_t = fl72.cone_full ? ccm_pkg::COV_ONE : qc;
    if (fl72.cone_hit && (cov_t > cov_a)) begin
      cov_a = cov_t;
    end
    cov_n = cov_a;
    if ((cov_a >= ccm_pkg::LIMIT_MIN_COV) && fl72.limit_out) begin
      if (fl72.limit_ramp) begin
        cov_n = (ql < cov_a) ? ql : cov_a;
      end else begin
        cov_n = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov <= cov_n;
    end
  end

  // Blend each channel from the outside color toward the inside color.
  logic [7:0] ch_o [0:3];
  logic [7:0] ch_i [0:3];
  logic signed [8:0] ch_diff [0:3];
  logic signed [26:0] ch_num [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ch_o[k] = outer_rgba[31-8*k -: 8];
      ch_i[k] = inner_rgba[31-8*k -: 8];
      ch_diff[k] = $signed({1'b0, ch_i[k]}) - $signed({1'b0, ch_o[k]});
      ch_num[k] = $signed({3'b0, ch_o[k], 16'b0}) + 27'(ch_diff[k] * $signed({1'b0, cov}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color.red <= ch_num[0][23:16];
      color.green <= ch_num[1][23:16];
      color.blue <= ch_num[2][23:16];
      color.alpha <= ch_num[3][23:16];
    end
  end

  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("Valid bits moved while the pipeline was held.");

  assert property (@(posedge clk) disable iff (rst) vld[LAT-1] |-> cov <= ccm_pkg::COV_ONE)
    else $error("Coverage exceeds one.");

  assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-2] && fl72.limit_out && !fl72.limit_ramp |=> cov < ccm_pkg::LIMIT_MIN_COV)
    else $error("Coverage survived beyond the outer limit.");

  assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-2] && fl72.disc_full |=> cov == ccm_pkg::COV_ONE || fl72 != $past(fl72) ||
      $past(fl72.limit_out))
    else $error("Full disc coverage was lost without an outer limit.");

endmodule

/* tb/circle_cone_mask_shader_checker.sv */
// Checker for the circle and cone mask shader: watches the pixel, color and
// config ports, predicts each color word and compares it. Depends on ccm_pkg.
module circle_cone_mask_shader_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  input  logic                  pixel_stall,
  input  ccm_pkg::pixel_word_t  pixel,
  input  logic                  color_valid,
  input  logic                  color_stall,
  input  ccm_pkg::color_word_t  color,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [47:0]           cfg_data,
  output int                    errors,
  output int                    pending
);

  logic [29:0] size_q;
  logic [31:0] inside_q, outside_q;
  logic [45:0] inner_q, outer_q;
  logic [32:0] cosines_q;
  logic [47:0] origin_q, dir_q;
  ccm_pkg::color_word_t expected_colors[$];

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic void normalize(input longint vx, input longint vy,
                                    output longint ux, output longint uy);
    longint unsigned ax, ay, m, len;
    ux = 0;
    uy = 0;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    if (ax == 0 && ay == 0) return;
    m = ax > ay ? ax : ay;
    while (m >= (64'd1 << 30)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    len = root_floor(ax * ax + ay * ay);
    ux = longint'((ax << 14) / len);
    uy = longint'((ay << 14) / len);
    if (vx < 0) ux = -ux;
    if (vy < 0) uy = -uy;
  endfunction

  function automatic longint clamp_dim(longint v);
    if (v == 0) return 1;
    if (v > ccm_pkg::MAX_DIM) return ccm_pkg::MAX_DIM;
    return v;
  endfunction

  function automatic ccm_pkg::color_word_t shade_pixel(ccm_pkg::pixel_word_t p);
    longint w, h, px, py, dx, dy, d, r, e, rl, sl, cov, t;
    longint c, cs, ox, oy, tx, ty, ax, ay, bx, by, cx, cy, kd, sd, o, i;
    logic [31:0] res;
    w = clamp_dim(size_q[29:15]);
    h = clamp_dim(size_q[14:0]);
    px = w > 1 ? p.pixel_x : 0;
    py = h > 1 ? p.pixel_y : 0;
    dx = px - w / 2;
    dy = py - h / 2;
    d = root_floor((dx * dx + dy * dy) << 16);
    r = inner_q[45:23];
    e = inner_q[22:0];
    rl = outer_q[45:23];
    sl = outer_q[22:0];
    cov = 0;
    if (d <= r + e) cov = d <= r ? 65536 : ((r + e - d) << 16) / e;
    if (cosines_q[32]) begin
      c = longint'($signed(cosines_q[31:16]));
      cs = longint'($signed(cosines_q[15:0]));
      ox = longint'($signed(origin_q[47:24]));
      oy = longint'($signed(origin_q[23:0]));
      tx = longint'($signed(dir_q[47:24]));
      ty = longint'($signed(dir_q[23:0]));
      normalize(-tx, -ty, ax, ay);
      normalize(px * 256 - ox, py * 256 - oy, bx, by);
      normalize(dx, dy, cx, cy);
      kd = (bx * ax + by * ay) / 16384;
      sd = (bx * cx + by * cy) / 16384;
      if (kd > cs && sd * 10 > -3 * 16384) begin
        t = kd > c ? 65536 : ((kd - cs) << 16) / (c - cs);
        if (t > cov) cov = t;
      end
    end
    if (cov * 10000 > 65536 && d > rl) begin
      if (d < rl + sl) begin
        t = ((rl + sl - d) << 16) / sl;
        if (t < cov) cov = t;
      end else begin
        cov = 0;
      end
    end
    for (int k = 0; k < 4; k++) begin
      o = outside_q[24 - 8 * k +: 8];
      i = inside_q[24 - 8 * k +: 8];
      res[24 - 8 * k +: 8] = 8'((o * 65536 + (i - o) * cov) >>> 16);
    end
    return ccm_pkg::color_word_t'(res);
  endfunction

  always @(posedge clk) begin
    ccm_pkg::color_word_t want;
    int fails;
    fails = 0;
    if (rst) begin
      size_q <= {15'd64, 15'd64};
      inside_q <= '1;
      outside_q <= '0;
      inner_q <= '0;
      outer_q <= '0;
      cosines_q <= '0;
      origin_q <= '0;
      dir_q <= '0;
      expected_colors.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (ccm_pkg::cfg_reg_t'(cfg_index))
          ccm_pkg::REG_IMAGE_SIZE: size_q <= cfg_data[29:0];
          ccm_pkg::REG_INNER_RGBA: inside_q <= cfg_data[31:0];
          ccm_pkg::REG_OUTER_RGBA: outside_q <= cfg_data[31:0];
          ccm_pkg::REG_CIRCLE_INNER: inner_q <= cfg_data[45:0];
          ccm_pkg::REG_CIRCLE_OUTER: outer_q <= cfg_data[45:0];
          ccm_pkg::REG_CONE_COSINES: cosines_q <= cfg_data[32:0];
          ccm_pkg::REG_CONE_ORIGIN: origin_q <= cfg_data;
          ccm_pkg::REG_CONE_DIRECTION: dir_q <= cfg_data;
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) expected_colors.push_back(shade_pixel(pixel));
      if (color_valid && !color_stall) begin
        if (expected_colors.size() == 0) begin
          $error("color word with no pixel pending: %h", color);
          fails++;
        end else begin
          want = expected_colors.pop_front();
          if (want.red !== color.red) begin
            $error("red expected %h actual %h", want.red, color.red);
            fails++;
          end
          if (want.green !== color.green) begin
            $error("green expected %h actual %h", want.green, color.green);
            fails++;
          end
          if (want.blue !== color.blue) begin
            $error("blue expected %h actual %h", want.blue, color.blue);
            fails++;
          end
          if (want.alpha !== color.alpha) begin
            $error("alpha expected %h actual %h", want.alpha, color.alpha);
            fails++;
          end
        end
      end
      errors <= errors + fails;
      pending <= expected_colors.size();
    end
  end
endmodule

/* tb/circle_cone_mask_shader_core_test.sv */
// Testbench top for the circle and cone mask shader: drives pixel words and
// register settings in phases of idling and stalls. Depends on ccm_pkg, the core and the checker.
module circle_cone_mask_shader_core_test;

  logic clk = 0;
  logic rst = 1;
  logic pixel_valid = 0;
  logic pixel_stall;
  ccm_pkg::pixel_word_t pixel = '0;
  logic color_valid;
  logic color_stall = 0;
  ccm_pkg::color_word_t color;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int errors, pending, send_idle, recv_stall, cycles;

  always #10 clk = ~clk;

  circle_cone_mask_shader_core i_dut (.*);
  circle_cone_mask_shader_checker i_check (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    color_stall <= ($urandom_range(99) < recv_stall);
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial cycles = 0;

  task automatic write_reg(ccm_pkg::cfg_reg_t idx, logic [47:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_pixel(logic [13:0] x, logic [13:0] y);
    while ($urandom_range(99) < send_idle) begin
      pixel_valid <= 0;
      @(posedge clk);
    end
    pixel_valid <= 1;
    pixel <= '{pixel_x: x, pixel_y: y};
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic drain;
    pixel_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_setup(int sel);
    logic [14:0] w, h;
    w = sel == 0 ? 15'd16384 : sel == 1 ? 15'd1 : 15'($urandom_range(1, 256));
    h = sel == 0 ? 15'h7fff : sel == 1 ? 15'd0 : 15'($urandom_range(1, 256));
    if (sel == 3) begin
      w = 15'($urandom);
      h = 15'($urandom);
    end
    write_reg(ccm_pkg::REG_IMAGE_SIZE, {18'd0, w, h});
    write_reg(ccm_pkg::REG_INNER_RGBA, {16'd0, 32'($urandom)});
    write_reg(ccm_pkg::REG_OUTER_RGBA, {16'd0, 32'($urandom)});
    write_reg(ccm_pkg::REG_CIRCLE_INNER, {2'd0, 23'($urandom_range(40000)),
                                          23'($urandom_range(sel == 2 ? 0 : 8000))});
    write_reg(ccm_pkg::REG_CIRCLE_OUTER, sel == 0 ? 48'h3fff_ffff_ffff :
              {2'd0, 23'($urandom_range(60000)), 23'($urandom_range(8000))});
    write_reg(ccm_pkg::REG_CONE_COSINES, {15'd0, 1'($urandom_range(3) != 0),
                                          16'($signed($urandom_range(32768)) - 16384),
                                          16'($signed($urandom_range(32768)) - 16384)});
    write_reg(ccm_pkg::REG_CONE_ORIGIN, sel == 0 ? 48'h7fffff_800000 :
              {24'($signed($urandom_range(131072)) - 65536),
               24'($signed($urandom_range(131072)) - 65536)});
    write_reg(ccm_pkg::REG_CONE_DIRECTION,
              sel == 1 ? 48'd0 : {24'($urandom), 24'($urandom)});
  endtask

  initial begin
    logic [13:0] span;
    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_pixel(14'd0, 14'd0);
    send_pixel(14'h3fff, 14'h3fff);
    send_pixel(14'd32, 14'd32);
    drain();
    write_reg(ccm_pkg::REG_CIRCLE_INNER, {2'd0, 23'd5000, 23'd2000});
    write_reg(ccm_pkg::REG_CIRCLE_OUTER, {2'd0, 23'd7000, 23'd0});
    write_reg(ccm_pkg::REG_CONE_COSINES, {15'd0, 1'b1, 16'sd14000, 16'sd15000});
    write_reg(ccm_pkg::REG_CONE_DIRECTION, {24'sd256, 24'sd0});
    for (int k = 0; k < 16; k++) send_pixel(14'(k * 4), 14'(k * 3 + 8));
    send_pixel(14'd0, 14'h3fff);
    send_pixel(14'h3fff, 14'd0);
    drain();
    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 71; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 71; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      random_setup(ph < 4 ? ph : 4 + ph % 2);
      span = ph % 5 == 0 ? 14'h3fff : 14'd300;
      for (int n = 0; n < 55; n++)
        send_pixel(14'($urandom_range(span)), 14'($urandom_range(span)));
      drain();
    end
    recv_stall = 0;
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/ccm_pkg.sv
sv/ccm_isqrt.sv
sv/ccm_div.sv
sv/ccm_unit.sv
sv/circle_cone_mask_shader_core.sv
tb/circle_cone_mask_shader_checker.sv
tb/circle_cone_mask_shader_core_test.sv
